// File: rtl/lcdw_pkg.sv
package lcdw_pkg;

  // Op codes
  localparam logic [1:0] OP_NUMBER = 2'd0;
  localparam logic [1:0] OP_GLYPH  = 2'd1;
  localparam logic [1:0] OP_BINARY = 2'd2;

  localparam int SEG_COUNT   = 7;
  localparam int POS_COUNT   = 3;
  localparam int GLYPH_COUNT = 13;
  localparam int RAM_INDEX_W = 4;
  localparam int VALUE_W     = 32;

  // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP10_SHIFT
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  typedef logic [SEG_COUNT-1:0] lit_t;

  // One classified command: segment pattern and enable per digit position
  typedef struct packed {
    logic [POS_COUNT-1:0]            en;
    logic [POS_COUNT-1:0][SEG_COUNT-1:0] lit;
  } cmd_t;

  // Glyph ROM: bit k lights segment k (A is bit 0, G is bit 6)
  localparam lit_t GLYPH_ROM [0:GLYPH_COUNT-1] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D,
    7'h07, 7'h7F, 7'h6F, 7'h1F, 7'h26, 7'h7B
  };

  // Image byte and bit mask for each position and segment A..G
  localparam logic [3:0] SEG_BYTE [0:POS_COUNT-1][0:SEG_COUNT-1] = '{
    '{4'd2, 4'd6, 4'd9, 4'd13, 4'd10, 4'd3, 4'd6},
    '{4'd2, 4'd5, 4'd9, 4'd13, 4'd9,  4'd2, 4'd6},
    '{4'd1, 4'd5, 4'd8, 4'd12, 4'd9,  4'd2, 4'd5}
  };
  localparam logic [7:0] SEG_MASK [0:POS_COUNT-1][0:SEG_COUNT-1] = '{
    '{8'h20, 8'h02, 8'h20, 8'h10, 8'h01, 8'h01, 8'h10},
    '{8'h04, 8'h40, 8'h04, 8'h01, 8'h10, 8'h10, 8'h01},
    '{8'h40, 8'h04, 8'h40, 8'h10, 8'h01, 8'h01, 8'h10}
  };

endpackage

// File: rtl/lcd_three_digit_segment_writer_unit.sv
// The image streams out one byte a cycle while out_tready is high, IMAGE_BYTES bytes per command.
// The first image byte of a glyph or binary command follows the command register, the queue and the
// image register; a number command first converts its value one decimal digit per step, one step per position.
// A two-entry command queue lets new commands be taken while the image streams out.
// Reset (rst_n low, synchronous) clears the segment image to zero and empties the pipeline.
module lcd_three_digit_segment_writer_unit
  import lcdw_pkg::*;
#(
  parameter int IMAGE_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op [1:0], value [33:2], position [35:34], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // ram_index [3:0], ram_byte [11:4], zero pad
  output logic        out_tlast
);

  logic                   push;
  cmd_t                   push_cmd;
  logic                   q_full;
  logic                   q_empty;
  logic                   pop;
  cmd_t                   q_head;
  logic [RAM_INDEX_W-1:0] ram_index;
  logic [7:0]             ram_byte;

  lcdw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tdata[1:0]),
    .in_value    (in_tdata[33:2]),
    .in_position (in_tdata[35:34]),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  lcdw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  lcdw_back #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (ram_index),
    .out_byte  (ram_byte),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'd0, ram_byte, ram_index};

endmodule

// File: rtl/lcdw_front.sv
module lcdw_front
  import lcdw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [1:0]         in_position,
  output logic               push,
  output cmd_t               push_cmd,
  input  logic               q_full
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [VALUE_W-1:0] v_r, v_nxt;
  cmd_t               cmd_r, cmd_nxt;

  logic               accept;
  logic [63:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot10;
  logic [3:0]         rem;
  logic [1:0]         dpos;
  lit_t               glyph_lit;
  lit_t               binary_lit;
  logic [5:0]         bits6;

  assign push     = done_r && !q_full;
  assign push_cmd = cmd_r;
  assign in_ready = !busy_r && (!done_r || push);
  assign accept   = in_valid && in_ready;

  // One decimal digit per cycle
  assign prod   = {32'd0, v_r} * {32'd0, RECIP10};
  assign quot   = VALUE_W'(prod[63:RECIP10_SHIFT]);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = 4'((v_r - quot10));
  assign dpos   = 2'(2'd2 - step_r);

  // Single glyph and binary pattern
  assign glyph_lit = (in_value < VALUE_W'(GLYPH_COUNT)) ? GLYPH_ROM[in_value[3:0]] : '0;
  assign bits6     = in_value[5:0];
  assign binary_lit = (bits6 == 6'd0) ? 7'h40 : {1'b0, bits6[4:0], bits6[5]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    v_nxt    = v_r;
    cmd_nxt  = cmd_r;
    if (push) begin
      done_nxt = 1'b0;
    end
    if (accept) begin
      step_nxt = 2'd0;
      v_nxt    = in_value;
      cmd_nxt.en = '0;
      case (in_op)
        OP_NUMBER: begin
          busy_nxt   = 1'b1;
          cmd_nxt.en = '1;
        end
        OP_GLYPH: begin
          done_nxt = 1'b1;
          for (int p = 0; p < POS_COUNT; p++) begin
            cmd_nxt.lit[p] = glyph_lit;
          end
          if (in_position <= 2'd2) begin
            cmd_nxt.en[in_position] = 1'b1;
          end
        end
        OP_BINARY: begin
          done_nxt = 1'b1;
          for (int p = 0; p < POS_COUNT; p++) begin
            cmd_nxt.lit[p] = binary_lit;
          end
          if (in_position <= 2'd2) begin
            cmd_nxt.en[in_position] = 1'b1;
          end
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      // Units always shown; a higher digit blanks once the quotient is zero
      if (step_r == 2'd0 || v_r != '0) begin
        cmd_nxt.lit[dpos] = GLYPH_ROM[rem];
      end else begin
        cmd_nxt.lit[dpos] = '0;
      end
      v_nxt    = quot;
      step_nxt = 2'(step_r + 2'd1);
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    v_r   <= v_nxt;
    cmd_r <= cmd_nxt;
  end

endmodule

// File: rtl/lcdw_queue.sv
module lcdw_queue
  import lcdw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       mem [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = 2'(count_r + 2'd1);
    end else if (pop && !push) begin
      count_nxt = 2'(count_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/lcdw_back.sv
module lcdw_back
  import lcdw_pkg::*;
#(
  parameter int IMAGE_BYTES = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  cmd_t                   q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RAM_INDEX_W-1:0] out_index,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  localparam int IDX_W = $clog2(IMAGE_BYTES);

  logic [7:0]       image_r   [0:IMAGE_BYTES-1];
  logic [7:0]       image_nxt [0:IMAGE_BYTES-1];
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_take;

  assign out_valid = busy_r;
  assign out_index = RAM_INDEX_W'(cnt_r);
  assign out_byte  = image_r[cnt_r];
  assign out_last  = (cnt_r == IDX_W'(IMAGE_BYTES - 1));
  assign out_take  = out_valid && out_ready;
  assign pop       = !q_empty && (!busy_r || (out_take && out_last));

  // Set or clear the mapped bits of the command at the head
  always_comb begin
    for (int i = 0; i < IMAGE_BYTES; i++) begin
      image_nxt[i] = image_r[i];
      for (int p = 0; p < POS_COUNT; p++) begin
        for (int s = 0; s < SEG_COUNT; s++) begin
          if (q_head.en[p] && SEG_BYTE[p][s] == RAM_INDEX_W'(i)) begin
            if (q_head.lit[p][s]) begin
              image_nxt[i] = image_nxt[i] | SEG_MASK[p][s];
            end else begin
              image_nxt[i] = image_nxt[i] & ~SEG_MASK[p][s];
            end
          end
        end
      end
    end
  end

  // Walk the image one byte per accepted output item
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (out_take) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = IDX_W'(cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < IMAGE_BYTES; i++) begin
        image_r[i] <= 8'd0;
      end
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        for (int i = 0; i < IMAGE_BYTES; i++) begin
          image_r[i] <= image_nxt[i];
        end
      end
    end
  end

endmodule
